// File: hdl/ihd_pkg.sv
// Shared types and constants for the cartridge header decoder.
// No dependencies; every other file takes its names from here.
package ihd_pkg;

	localparam int HDR_BYTES = 16;
	localparam logic [3:0] LAST_IDX = 4'(HDR_BYTES - 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int IN_W = 8;
	localparam int OUT_W = 64;
	localparam int CFG_W = 32;
	localparam int PRG_PAGE_BYTES_DEF = 16384;
	localparam int CHR_PAGE_BYTES_DEF = 8192;

	// magic characters
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_U = 8'h55;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_EOF = 8'h1A;

	localparam logic [13:0] SRAM_DEFAULT = 14'h2000;
	localparam logic [1:0] NES2_ID = 2'b10;

	typedef enum logic [1:0] {
		FMT_INES    = 2'd0,
		FMT_NSF     = 2'd1,
		FMT_UNIF    = 2'd2,
		FMT_UNKNOWN = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		VER_ARCHAIC = 2'd0,
		VER_INES1   = 2'd1,
		VER_NES2    = 2'd2
	} ver_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_MAPPER0_BIG = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	// header as handed from front to back
	typedef struct packed {
		fmt_t       fmt;
		logic [7:0] b4;
		logic [7:0] b5;
		logic [7:0] b6;
		logic [7:0] b7;
		logic [7:0] b8;
		logic [7:0] b9;
		logic [7:0] b10;
		logic       tail_zero;   // bytes 12..15 all zero
	} hdr_rec_t;

	// result item, last field in the lowest bits
	typedef struct packed {
		status_t     mapper_status;
		logic        second_prg_bank;
		logic        has_playchoice;
		logic [13:0] save_ram_size;
		logic        has_save_ram;
		logic        has_trainer;
		logic [11:0] chr_pages;
		logic [11:0] prg_pages;
		logic [3:0]  submapper;
		logic [11:0] mapper;
		ver_t        version;
		fmt_t        format;
	} result_t;

endpackage

// File: hdl/ihd_front.sv
// Front end: takes header bytes, keeps bytes 0..14, and on byte 15 sends a
// classified header record to the queue. Depends on ihd_pkg.
module ihd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   in_first,
	output logic                   rec_valid,
	input  logic                   rec_ready,
	output ihd_pkg::hdr_rec_t      rec
);

	logic [3:0] cnt_q;
	logic [7:0] hdr_q [0:14];
	logic [3:0] idx;
	logic       acc;
	ihd_pkg::fmt_t fmt;

	assign in_ready = rec_ready;
	assign acc      = in_valid && rec_ready;
	assign idx      = in_first ? 4'd0 : cnt_q;
	assign rec_valid = acc && (idx == ihd_pkg::LAST_IDX);

	always_comb begin
		if (hdr_q[0] == ihd_pkg::CH_N && hdr_q[1] == ihd_pkg::CH_E &&
		    hdr_q[2] == ihd_pkg::CH_S && hdr_q[3] == ihd_pkg::CH_EOF) begin
			fmt = ihd_pkg::FMT_INES;
		end else if (hdr_q[0] == ihd_pkg::CH_N && hdr_q[1] == ihd_pkg::CH_E &&
		             hdr_q[2] == ihd_pkg::CH_S && hdr_q[3] == ihd_pkg::CH_M &&
		             hdr_q[4] == ihd_pkg::CH_EOF) begin
			fmt = ihd_pkg::FMT_NSF;
		end else if (hdr_q[0] == ihd_pkg::CH_U && hdr_q[1] == ihd_pkg::CH_N &&
		             hdr_q[2] == ihd_pkg::CH_I && hdr_q[3] == ihd_pkg::CH_F) begin
			fmt = ihd_pkg::FMT_UNIF;
		end else begin
			fmt = ihd_pkg::FMT_UNKNOWN;
		end
		rec.fmt       = fmt;
		rec.b4        = hdr_q[4];
		rec.b5        = hdr_q[5];
		rec.b6        = hdr_q[6];
		rec.b7        = hdr_q[7];
		rec.b8        = hdr_q[8];
		rec.b9        = hdr_q[9];
		rec.b10       = hdr_q[10];
		// byte 15 is the one arriving now
		rec.tail_zero = (hdr_q[12] == 8'd0) && (hdr_q[13] == 8'd0) &&
		                (hdr_q[14] == 8'd0) && (in_byte == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (acc) begin
			cnt_q <= idx + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && idx != ihd_pkg::LAST_IDX) begin
			hdr_q[idx] <= in_byte;
		end
	end

endmodule

// File: hdl/ihd_queue.sv
// Short queue of header records between front and back end.
// Depends on ihd_pkg.
module ihd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  ihd_pkg::hdr_rec_t wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output ihd_pkg::hdr_rec_t rd_data
);

	localparam int DEPTH = ihd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ihd_pkg::hdr_rec_t mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hdl/ihd_back.sv
// Back end: page-size products in stage 1, size check and field decode
// into the output register. Depends on ihd_pkg.
module ihd_back #(
	parameter int PRG_PAGE_BYTES = ihd_pkg::PRG_PAGE_BYTES_DEF,
	parameter int CHR_PAGE_BYTES = ihd_pkg::CHR_PAGE_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ihd_pkg::CFG_W-1:0] file_length,
	input  logic                      rec_valid,
	output logic                      rec_ready,
	input  ihd_pkg::hdr_rec_t         rec,
	output logic                      out_valid,
	input  logic                      out_ready,
	output ihd_pkg::result_t          result
);

	localparam int PRG_PROD_W = 12 + $clog2(PRG_PAGE_BYTES + 1);
	localparam int CHR_PROD_W = 12 + $clog2(CHR_PAGE_BYTES + 1);
	localparam int NEED_W = ((PRG_PROD_W > CHR_PROD_W) ? PRG_PROD_W : CHR_PROD_W) + 1;
	localparam int CMP_W = (NEED_W > ihd_pkg::CFG_W) ? NEED_W : ihd_pkg::CFG_W;

	logic                    v_s1;
	ihd_pkg::hdr_rec_t       rec_s1;
	logic [PRG_PROD_W-1:0]   prg_prod_s1;
	logic [CHR_PROD_W-1:0]   chr_prod_s1;
	logic                    s1_ready, adv_out;
	logic                    out_valid_q;
	ihd_pkg::result_t        result_q, res_c;

	logic [11:0] ext_prg_in, ext_chr_in;
	logic [11:0] ext_prg, ext_chr, prg, chr, mapper;
	logic [CMP_W-1:0] need;
	logic nes2, ines1, batt;

	assign adv_out   = !out_valid_q || out_ready;
	assign s1_ready  = !v_s1 || adv_out;
	assign rec_ready = s1_ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	assign ext_prg_in = {rec.b9[3:0], rec.b4};
	assign ext_chr_in = {rec.b9[7:4], rec.b5};

	always_comb begin
		ext_prg = {rec_s1.b9[3:0], rec_s1.b4};
		ext_chr = {rec_s1.b9[7:4], rec_s1.b5};
		need    = CMP_W'(prg_prod_s1) + CMP_W'(chr_prod_s1);
		batt    = rec_s1.b6[1];
		nes2    = (rec_s1.b7[3:2] == ihd_pkg::NES2_ID) && (need < CMP_W'(file_length));
		ines1   = (rec_s1.b7[3:2] == 2'b00) && rec_s1.tail_zero;
		mapper  = {4'd0, rec_s1.b7[7:4], rec_s1.b6[7:4]};
		prg     = {4'd0, rec_s1.b4};
		chr     = {4'd0, rec_s1.b5};

		res_c = '0;
		res_c.format = rec_s1.fmt;
		if (rec_s1.fmt == ihd_pkg::FMT_INES) begin
			res_c.save_ram_size = batt ? ihd_pkg::SRAM_DEFAULT : 14'd0;
			if (nes2) begin
				res_c.version = ihd_pkg::VER_NES2;
				prg = ext_prg;
				chr = ext_chr;
				mapper[11:8] = rec_s1.b8[3:0];
				res_c.submapper = rec_s1.b8[7:4];
				if (batt) begin
					res_c.save_ram_size = {3'd0, rec_s1.b10[3:0], 7'd0};
				end
			end else if (ines1) begin
				res_c.version = ihd_pkg::VER_INES1;
			end else begin
				res_c.version = ihd_pkg::VER_ARCHAIC;
			end
			res_c.mapper         = mapper;
			res_c.prg_pages      = prg;
			res_c.chr_pages      = chr;
			res_c.has_trainer    = rec_s1.b6[2];
			res_c.has_save_ram   = batt;
			res_c.has_playchoice = rec_s1.b7[1];
			if (mapper != 12'd0) begin
				res_c.mapper_status = ihd_pkg::ST_UNSUPPORTED;
			end else if (prg > 12'd2 || chr > 12'd1) begin
				res_c.mapper_status = ihd_pkg::ST_MAPPER0_BIG;
			end else begin
				res_c.mapper_status   = ihd_pkg::ST_OK;
				res_c.second_prg_bank = (prg == 12'd2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= rec_valid;
			end
			if (adv_out) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && rec_valid) begin
			rec_s1      <= rec;
			prg_prod_s1 <= PRG_PROD_W'(ext_prg_in) * PRG_PROD_W'(PRG_PAGE_BYTES);
			chr_prod_s1 <= CHR_PROD_W'(ext_chr_in) * CHR_PROD_W'(CHR_PAGE_BYTES);
		end
		if (adv_out && v_s1) begin
			result_q <= res_c;
		end
	end

endmodule

// File: hdl/ines_header_decoder.sv
// Top level of the cartridge header decoder: front end, record queue and
// back end. Depends on ihd_pkg, ihd_front, ihd_queue and ihd_back.
//
// Use:
//   s_* carries header bytes, one item per byte, in file order. s_tuser
//   high marks byte 0 of a new header and drops any partial one; without
//   it the byte count simply wraps after sixteen bytes.
//   m_* carries one decoded result item per complete header (sixteen
//   bytes). No item comes out for bytes 0 to 14.
//   cfg_* writes the image length in bytes; it is always ready. It is to be
//   written only while no header is in flight; the block does not enforce it.
// Throughput: one byte per cycle while s_tready is high.
// Result path: once the sixteenth byte is taken, the header passes through the
//   queue entry, the product stage and the decode into the output register.
// Stall: while m_tready is low the result holds; further headers collect
//   in the two-entry queue and s_tready drops only once it is full.
// Reset: clears the byte count, queue and valid flags; the image length
//   resets to zero. No clearing pass.
module ines_header_decoder #(
	parameter int PRG_PAGE_BYTES = ihd_pkg::PRG_PAGE_BYTES_DEF,
	parameter int CHR_PAGE_BYTES = ihd_pkg::CHR_PAGE_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ihd_pkg::IN_W-1:0]  s_tdata,    // [7:0] header_byte
	input  logic                      s_tuser,    // [0] first_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [1:0] format, [3:2] version, [15:4] mapper, [19:16] submapper,
	// [31:20] prg_pages, [43:32] chr_pages, [44] has_trainer,
	// [45] has_save_ram, [59:46] save_ram_size, [60] has_playchoice,
	// [61] second_prg_bank, [63:62] mapper_status
	output logic [ihd_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ihd_pkg::CFG_W-1:0] cfg_data    // file_length
);

	logic [ihd_pkg::CFG_W-1:0] file_length_q;

	logic              fq_valid, fq_ready;
	ihd_pkg::hdr_rec_t fq_rec;
	logic              qb_valid, qb_ready;
	ihd_pkg::hdr_rec_t qb_rec;
	ihd_pkg::result_t  result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_valid) begin
			file_length_q <= cfg_data;
		end
	end

	// byte collection and magic check
	ihd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_first  (s_tuser),
		.rec_valid (fq_valid),
		.rec_ready (fq_ready),
		.rec       (fq_rec)
	);

	// decouples byte intake from a stalled output
	ihd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_rec),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_rec)
	);

	// version check and field decode
	ihd_back #(
		.PRG_PAGE_BYTES (PRG_PAGE_BYTES),
		.CHR_PAGE_BYTES (CHR_PAGE_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.file_length (file_length_q),
		.rec_valid   (qb_valid),
		.rec_ready   (qb_ready),
		.rec         (qb_rec),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.result      (result)
	);

	assign m_tdata = result;

endmodule

// File: hdl/ihd_checker.sv
// Port-level checks for the header decoder, bound to the top level.
// Depends on ihd_pkg and ines_header_decoder.
module ihd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [ihd_pkg::OUT_W-1:0] m_tdata
);

	ihd_pkg::result_t res;
	assign res = m_tdata;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// non-iNES results carry only the format
	a_non_ines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.format != ihd_pkg::FMT_INES |-> m_tdata[ihd_pkg::OUT_W-1:2] == '0)
		else $error("non-iNES result has fields set");

	// bank choice only with ok status
	a_bank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.mapper_status != ihd_pkg::ST_OK |-> !res.second_prg_bank)
		else $error("second bank set with bad status");

	// no battery, no save RAM
	a_sram: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.has_save_ram |-> res.save_ram_size == 14'd0)
		else $error("save RAM size without battery");

endmodule

bind ines_header_decoder ihd_checker u_ihd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
